[design/rle_pixel_decoder_assert.svh]
// Assertion macros for the run-length pixel decoder checker.
// Depends on nothing; included by the checker file.
`ifndef RLE_PIXEL_DECODER_ASSERT_SVH
`define RLE_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, disabled in reset.
`define RLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, disabled in reset.
`define RLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rle_pkg.sv]
// Shared constants and control types of the run-length pixel decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package rle_pkg;

    // Group size and largest pixel size, with their effective clamped values.
    localparam int GROUP_PIXELS    = 4;
    localparam int MAX_PIXEL_BYTES = 4;
    localparam int GROUP_EFF = (GROUP_PIXELS < 1) ? 1 :
                               ((GROUP_PIXELS > 4) ? 4 : GROUP_PIXELS);
    localparam int PB_MAX    = (MAX_PIXEL_BYTES < 1) ? 1 : MAX_PIXEL_BYTES;

    // Field widths.
    localparam int PIX_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int PB_W      = 3;
    localparam int LIMIT_W   = 32;
    localparam int CNT_W     = 3;
    localparam int LEFT_W    = 8;
    localparam int SLOT_W    = 4;
    localparam int OFS_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Header bytes above this value start a run.
    localparam logic [BYTE_W-1:0] RUN_THRESHOLD = 8'd127;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd1;

    // Configuration reset values.
    localparam logic [PB_W-1:0]    PB_RESET    = 3'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic emit_step;
    } rle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic starts_emit;
        logic group_final;
        logic out_free;
    } rle_status_t;

endpackage

[design/rle_pixel_decoder.sv]
// Run-length pixel decoder: compressed bytes in, groups of
// up to four decoded pixels out. Input, output and configuration channels
// use valid/ready; an item moves when valid and ready are both high.
// Configuration: cfg_index 0 sets pixel_bytes, 1 sets output_limit; cfg_ready
// is always high. Writes must be made only while the block is idle; the
// block itself does not enforce this. A byte that does not complete a pixel
// is simply taken. A byte that completes a pixel is followed by the emission
// of its groups, one group for a literal pixel and ceil(n/4) for a run of n
// pixels unless the output limit ends it early; the group emission loop in
// the controller sets this, and no byte is accepted while it runs. A group
// is held in an output register, so the decoder keeps parsing while a result
// waits; if the receiver stalls, emission pauses until the register frees.
// Reset restores pixel_bytes 2, output_limit all ones and an empty parse
// state; the byte flagged last_byte clears the parse state at once and the
// byte count once its pixels are out.
// Depends on rle_pkg, rle_controller and rle_datapath.
module rle_pixel_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rle_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rle_pkg::BYTE_W-1:0]      in_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rle_pkg::PIX_W-1:0]       pixel_a,
    output logic [rle_pkg::PIX_W-1:0]       pixel_b,
    output logic [rle_pkg::PIX_W-1:0]       pixel_c,
    output logic [rle_pkg::PIX_W-1:0]       pixel_d,
    output logic [rle_pkg::CNT_W-1:0]       pixel_count,
    output logic                            last_of_run,
    output logic                            limit_hit
);

    rle_pkg::rle_cmd_t    cmd;
    rle_pkg::rle_status_t status;
    logic                 cfg_we;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    rle_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rle_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_byte     (in_byte),
        .last_byte   (last_byte),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .pixel_a     (pixel_a),
        .pixel_b     (pixel_b),
        .pixel_c     (pixel_c),
        .pixel_d     (pixel_d),
        .pixel_count (pixel_count),
        .last_of_run (last_of_run),
        .limit_hit   (limit_hit)
    );

endmodule

[design/rle_controller.sv]
// Controller of the run-length pixel decoder: accepts bytes and sequences
// pixel group emission. Depends on rle_pkg for the command and status types.
module rle_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rle_pkg::rle_status_t status,
    output rle_pkg::rle_cmd_t    cmd
);

    typedef enum logic [1:0]
    {
        ST_ACCEPT = 2'b01,
        ST_EMIT   = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Bytes are taken only while no emission is under way.
    always_comb
    begin
        in_ready      = (state_reg == ST_ACCEPT);
        cmd.take_byte = in_ready && in_valid;
        cmd.emit_step = (state_reg == ST_EMIT) && status.out_free;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (cmd.take_byte && status.starts_emit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit_step && status.group_final)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/rle_datapath.sv]
// Datapath of the run-length pixel decoder: configuration, byte parsing,
// limit checks and the output register. Depends on rle_pkg.
module rle_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rle_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rle_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic [rle_pkg::BYTE_W-1:0]          in_byte,
    input  logic                                last_byte,
    input  rle_pkg::rle_cmd_t                   cmd,
    output rle_pkg::rle_status_t                status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [rle_pkg::PIX_W-1:0]           pixel_a,
    output logic [rle_pkg::PIX_W-1:0]           pixel_b,
    output logic [rle_pkg::PIX_W-1:0]           pixel_c,
    output logic [rle_pkg::PIX_W-1:0]           pixel_d,
    output logic [rle_pkg::CNT_W-1:0]           pixel_count,
    output logic                                last_of_run,
    output logic                                limit_hit
);

    typedef enum logic [2:0]
    {
        PH_HEADER  = 3'b001,
        PH_RUN     = 3'b010,
        PH_LITERAL = 3'b100
    } phase_t;

    // Configuration registers.
    logic [rle_pkg::PB_W-1:0]    pb_reg,    pb_next;
    logic [rle_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    // Parse state.
    phase_t                      phase_reg, phase_next;
    logic [rle_pkg::LEFT_W-1:0]  left_reg,  left_next;
    logic [rle_pkg::SLOT_W-1:0]  slot_reg,  slot_next;
    logic [rle_pkg::PIX_W-1:0]   build_reg, build_next;

    // Limit and emission state.
    logic [rle_pkg::LIMIT_W-1:0] bytes_out_reg, bytes_out_next;
    logic                        stopped_reg,   stopped_next;
    logic [rle_pkg::LEFT_W-1:0]  emit_left_reg, emit_left_next;
    logic [rle_pkg::PIX_W-1:0]   emit_pix_reg,  emit_pix_next;
    logic                        last_pend_reg, last_pend_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic [rle_pkg::PIX_W-1:0]   out_pix_reg  [4];
    logic [rle_pkg::PIX_W-1:0]   out_pix_next [4];
    logic [rle_pkg::CNT_W-1:0]   count_reg,     count_next;
    logic                        lor_reg,       lor_next;
    logic                        hit_reg,       hit_next;

    // Combinational helpers.
    logic [rle_pkg::PB_W-1:0]    pb_eff;
    logic [rle_pkg::SLOT_W-1:0]  slot_inc;
    logic                        pixel_done;
    logic [rle_pkg::PIX_W-1:0]   build_base;
    logic [rle_pkg::PIX_W-1:0]   build_new;
    logic                        starts_emit;
    logic [rle_pkg::CNT_W-1:0]   avail;
    logic [rle_pkg::GROUP_EFF:0] fit;
    logic [rle_pkg::CNT_W-1:0]   count;
    logic                        fit_after;
    logic                        stop_after;
    logic                        group_final;
    logic [rle_pkg::OFS_W-1:0]   add_bytes;
    logic                        out_free;

    // Effective pixel size: zero acts as one, large values clamp.
    always_comb
    begin
        if (pb_reg == '0)
        begin
            pb_eff = rle_pkg::PB_W'(1);
        end
        else if (int'(pb_reg) > rle_pkg::PB_MAX)
        begin
            pb_eff = rle_pkg::PB_W'(rle_pkg::PB_MAX);
        end
        else
        begin
            pb_eff = pb_reg;
        end
    end

    // Pixel assembly: bytes enter little-endian, only the first four are kept.
    always_comb
    begin
        slot_inc   = slot_reg + rle_pkg::SLOT_W'(1);
        pixel_done = (slot_inc >= rle_pkg::SLOT_W'(pb_eff));
        build_base = (slot_reg == '0) ? '0 : build_reg;
        if (slot_reg < rle_pkg::SLOT_W'(4))
        begin
            build_new = build_base |
                        (rle_pkg::PIX_W'(in_byte) << {slot_reg[1:0], 3'b000});
        end
        else
        begin
            build_new = build_base;
        end
        starts_emit = (phase_reg != PH_HEADER) && pixel_done && !stopped_reg;
    end

    // Limit checks for the next group: fit[k] says k+1 more pixels still fit.
    always_comb
    begin
        logic [rle_pkg::OFS_W-1:0]   ofs;
        logic [rle_pkg::LIMIT_W:0]   total;
        if (emit_left_reg < rle_pkg::LEFT_W'(rle_pkg::GROUP_EFF))
        begin
            avail = emit_left_reg[rle_pkg::CNT_W-1:0];
        end
        else
        begin
            avail = rle_pkg::CNT_W'(rle_pkg::GROUP_EFF);
        end
        for (int k = 0; k <= rle_pkg::GROUP_EFF; k++)
        begin
            ofs    = rle_pkg::OFS_W'(k + 1) * rle_pkg::OFS_W'(pb_eff);
            total  = {1'b0, bytes_out_reg} + (rle_pkg::LIMIT_W + 1)'(ofs);
            fit[k] = (total <= {1'b0, limit_reg});
        end
        count = '0;
        for (int k = 0; k < rle_pkg::GROUP_EFF; k++)
        begin
            if ((rle_pkg::CNT_W'(k) < avail) && fit[k])
            begin
                count = rle_pkg::CNT_W'(k + 1);
            end
        end
        fit_after = 1'b0;
        for (int k = 0; k <= rle_pkg::GROUP_EFF; k++)
        begin
            if (rle_pkg::CNT_W'(k) == count)
            begin
                fit_after = fit[k];
            end
        end
        stop_after  = (count == '0) || !fit_after;
        group_final = (emit_left_reg == rle_pkg::LEFT_W'(count)) || stop_after;
        add_bytes   = rle_pkg::OFS_W'(count) * rle_pkg::OFS_W'(pb_eff);
        out_free    = !out_valid_reg || out_ready;
    end

    // Status toward the controller.
    always_comb
    begin
        status.starts_emit = starts_emit;
        status.group_final = group_final;
        status.out_free    = out_free;
    end

    // Next-state logic for configuration, parsing, emission and output.
    always_comb
    begin
        pb_next        = pb_reg;
        limit_next     = limit_reg;
        phase_next     = phase_reg;
        left_next      = left_reg;
        slot_next      = slot_reg;
        build_next     = build_reg;
        bytes_out_next = bytes_out_reg;
        stopped_next   = stopped_reg;
        emit_left_next = emit_left_reg;
        emit_pix_next  = emit_pix_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        count_next     = count_reg;
        lor_next       = lor_reg;
        hit_next       = hit_reg;

        // Configuration writes must arrive only while the block is idle; the block does not enforce this.
        if (cfg_we)
        begin
            if (cfg_index == rle_pkg::REG_PIXEL_BYTES)
            begin
                pb_next = cfg_data[rle_pkg::PB_W-1:0];
            end
            else if (cfg_index == rle_pkg::REG_OUTPUT_LIMIT)
            begin
                limit_next = cfg_data[rle_pkg::LIMIT_W-1:0];
            end
        end

        // Take one compressed byte.
        if (cmd.take_byte)
        begin
            if (phase_reg == PH_HEADER)
            begin
                if (in_byte > rle_pkg::RUN_THRESHOLD)
                begin
                    left_next  = in_byte - rle_pkg::RUN_THRESHOLD;
                    phase_next = PH_RUN;
                end
                else if (in_byte != '0)
                begin
                    left_next  = in_byte;
                    phase_next = PH_LITERAL;
                end
                slot_next  = '0;
                build_next = '0;
            end
            else
            begin
                build_next = build_new;
                slot_next  = pixel_done ? '0 : slot_inc;
                if (pixel_done)
                begin
                    emit_pix_next = build_new;
                    if (phase_reg == PH_RUN)
                    begin
                        emit_left_next = left_reg;
                        left_next      = '0;
                        phase_next     = PH_HEADER;
                    end
                    else
                    begin
                        emit_left_next = rle_pkg::LEFT_W'(1);
                        left_next      = left_reg - rle_pkg::LEFT_W'(1);
                        if (left_reg == rle_pkg::LEFT_W'(1))
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
            end

            // End of image: parse state clears now, counters after emission.
            if (last_byte)
            begin
                phase_next = PH_HEADER;
                left_next  = '0;
                slot_next  = '0;
                build_next = '0;
                if (starts_emit)
                begin
                    last_pend_next = 1'b1;
                end
                else
                begin
                    bytes_out_next = '0;
                    stopped_next   = 1'b0;
                end
            end
        end

        // The receiver takes the held item.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Emit one group of pixels.
        if (cmd.emit_step)
        begin
            if (count != '0)
            begin
                out_valid_next = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    out_pix_next[k] = (rle_pkg::CNT_W'(k) < count) ? emit_pix_reg : '0;
                end
                count_next     = count;
                lor_next       = group_final;
                hit_next       = stop_after;
                bytes_out_next = bytes_out_reg + rle_pkg::LIMIT_W'(add_bytes);
            end
            stopped_next   = stop_after;
            emit_left_next = emit_left_reg - rle_pkg::LEFT_W'(count);
            if (group_final && last_pend_reg)
            begin
                bytes_out_next = '0;
                stopped_next   = 1'b0;
                last_pend_next = 1'b0;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg        <= rle_pkg::PB_RESET;
            limit_reg     <= rle_pkg::LIMIT_RESET;
            phase_reg     <= PH_HEADER;
            left_reg      <= '0;
            slot_reg      <= '0;
            build_reg     <= '0;
            bytes_out_reg <= '0;
            stopped_reg   <= 1'b0;
            emit_left_reg <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pb_reg        <= pb_next;
            limit_reg     <= limit_next;
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            slot_reg      <= slot_next;
            build_reg     <= build_next;
            bytes_out_reg <= bytes_out_next;
            stopped_reg   <= stopped_next;
            emit_left_reg <= emit_left_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        emit_pix_reg <= emit_pix_next;
        out_pix_reg  <= out_pix_next;
        count_reg    <= count_next;
        lor_reg      <= lor_next;
        hit_reg      <= hit_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_a     = out_pix_reg[0];
    assign pixel_b     = out_pix_reg[1];
    assign pixel_c     = out_pix_reg[2];
    assign pixel_d     = out_pix_reg[3];
    assign pixel_count = count_reg;
    assign last_of_run = lor_reg;
    assign limit_hit   = hit_reg;

endmodule

[design/rle_checker.sv]
// Port-level checker of the run-length pixel decoder, bound to the top level.
// Depends on rle_pkg and the macros in rle_pixel_decoder_assert.svh.
`include "rle_pixel_decoder_assert.svh"

module rle_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rle_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [rle_pkg::BYTE_W-1:0]      in_byte,
    input  logic                            last_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [rle_pkg::PIX_W-1:0]       pixel_a,
    input  logic [rle_pkg::PIX_W-1:0]       pixel_b,
    input  logic [rle_pkg::PIX_W-1:0]       pixel_c,
    input  logic [rle_pkg::PIX_W-1:0]       pixel_d,
    input  logic [rle_pkg::CNT_W-1:0]       pixel_count,
    input  logic                            last_of_run,
    input  logic                            limit_hit
);

    // A stalled item holds its count and flags.
    `RLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_count) && $stable(last_of_run) && $stable(limit_hit), "stalled output item changed")

    // Every item carries between one and four pixels.
    `RLE_ASSERT_NOW(a_count_range, out_valid, pixel_count >= 3'd1 && pixel_count <= 3'd4, "pixel_count out of range")

    // Pixel fields beyond the count are zero.
    `RLE_ASSERT_NOW(a_unused_zero, out_valid && pixel_count < 3'd4, pixel_d == '0 && (pixel_count >= 3'd3 || pixel_c == '0) && (pixel_count >= 3'd2 || pixel_b == '0), "unused pixel field not zero")

    // Reaching the limit always ends the results of that byte.
    `RLE_ASSERT_NOW(a_hit_ends, out_valid && limit_hit, last_of_run, "limit_hit without last_of_run")

endmodule

bind rle_pixel_decoder rle_checker u_rle_checker (.*);
